[src/rc_frame_checker_macros.svh]
`ifndef RC_FRAME_CHECKER_MACROS_SVH
`define RC_FRAME_CHECKER_MACROS_SVH

// next-cycle implication, reset disables
`define RC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// same-cycle implication, reset disables
`define RC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/rc_fc_pkg.sv]
package rc_fc_pkg;

  localparam int unsigned CHANNELS = 10;
  localparam int unsigned CHAN_BYTES = 2 * CHANNELS;
  localparam int unsigned MIN_FRAME_BYTES = 28;
  localparam int unsigned CHAN_FIRST_BYTE = 4;
  localparam logic [7:0] HEADER_FIRST = 8'hAA;
  localparam logic [7:0] HEADER_SECOND = 8'hAF;
  localparam logic [7:0] FUNCTION_RESET = 8'h03;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_FUNC   = 3'd2,
    ST_BAD_SUM    = 3'd3,
    ST_BAD_LEN    = 3'd4
  } status_t;

  typedef logic [CHANNELS-1:0][15:0] chan_set_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } frame_end_t;

endpackage

[src/rc_fc_parser.sv]
module rc_fc_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_data,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output rc_fc_pkg::frame_end_t frame_end,
  output rc_fc_pkg::chan_set_t  pending
);
  import rc_fc_pkg::*;

  logic [7:0]  function_code;
  logic [7:0]  byte_index;
  logic        header_ok;
  logic        function_ok;
  logic [31:0] running_sum;
  logic [7:0]  tail_window [4];
  logic [7:0]  pend_bytes [CHAN_BYTES];

  logic        header_next;
  logic        function_next;
  logic [31:0] running_sum_next;
  logic [31:0] check;
  logic        bad_len;
  status_t     status;

  always_comb begin
    header_next = header_ok;
    function_next = function_ok;
    if (byte_index == 8'd0) begin
      header_next = (data_byte == HEADER_FIRST);
    end else if (byte_index == 8'd1) begin
      header_next = header_ok && (data_byte == HEADER_SECOND);
    end else if (byte_index == 8'd2) begin
      function_next = (data_byte == function_code);
    end
  end

  assign running_sum_next = (byte_index >= 8'(CHAN_FIRST_BYTE)) ?
                            running_sum + {24'd0, tail_window[0]} : running_sum;
  assign check = {tail_window[1], tail_window[2], tail_window[3], data_byte};
  assign bad_len = (byte_index < 8'(MIN_FRAME_BYTES - 1)) ||
                   ({1'b0, byte_index} >= 9'(MAX_FRAME_BYTES));

  always_comb begin
    priority if (bad_len) begin
      status = ST_BAD_LEN;
    end else if (!header_next) begin
      status = ST_BAD_HEADER;
    end else if (!function_next) begin
      status = ST_BAD_FUNC;
    end else if (check != running_sum_next) begin
      status = ST_BAD_SUM;
    end else begin
      status = ST_OK;
    end
  end

  assign frame_end.done = take && last_byte;
  assign frame_end.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_code <= FUNCTION_RESET;
    end else if (cfg_valid) begin
      function_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      header_ok <= 1'b1;
      function_ok <= 1'b1;
      running_sum <= '0;
      for (int i = 0; i < 4; i++) tail_window[i] <= '0;
    end else if (take) begin
      if (last_byte) begin
        byte_index <= '0;
        header_ok <= 1'b1;
        function_ok <= 1'b1;
        running_sum <= '0;
        for (int i = 0; i < 4; i++) tail_window[i] <= '0;
      end else begin
        if (byte_index != 8'hFF) begin
          byte_index <= byte_index + 8'd1;
        end
        header_ok <= header_next;
        function_ok <= function_next;
        running_sum <= running_sum_next;
        tail_window[0] <= tail_window[1];
        tail_window[1] <= tail_window[2];
        tail_window[2] <= tail_window[3];
        tail_window[3] <= data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHAN_BYTES; i++) pend_bytes[i] <= '0;
    end else if (take) begin
      for (int i = 0; i < CHAN_BYTES; i++) begin
        if (byte_index == 8'(i + CHAN_FIRST_BYTE)) begin
          pend_bytes[i] <= data_byte;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      pending[k] = {pend_bytes[2*k], pend_bytes[2*k+1]};
    end
  end

endmodule

[src/rc_fc_result.sv]
module rc_fc_result (
  input  logic                  clk,
  input  logic                  rst,
  input  rc_fc_pkg::frame_end_t frame_end,
  input  rc_fc_pkg::chan_set_t  pending,
  input  logic                  out_ready,
  output logic                  free,
  output logic                  out_valid,
  output logic [2:0]            status,
  output rc_fc_pkg::chan_set_t  accepted
);
  import rc_fc_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      accepted <= '0;
    end else begin
      if (frame_end.done) begin
        out_valid <= 1'b1;
        if (frame_end.status == ST_OK) begin
          accepted <= pending;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end.done) begin
      status <= frame_end.status;
    end
  end

endmodule

[src/rc_frame_checker.sv]
// Remote-control frame checker. Takes one frame byte per request on the input
// channel (last_byte marks the end) and returns one result per frame: a status
// and the ten held channels, which change only when a frame passes every check
// (length, header 0xAA 0xAF, function byte, 32-bit additive checksum). One byte
// is taken every clock cycle; the only stall is a result waiting on out_ready,
// set by the single output register. A result appears in the cycle after its last
// byte. The function byte is written through the cfg channel, which never stalls.
module rc_frame_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [15:0] throttle,
  output logic signed [15:0] yaw_stick,
  output logic signed [15:0] roll_stick,
  output logic signed [15:0] pitch_stick,
  output logic signed [15:0] aux_one,
  output logic signed [15:0] aux_two,
  output logic signed [15:0] aux_three,
  output logic signed [15:0] aux_four,
  output logic signed [15:0] aux_five,
  output logic signed [15:0] aux_six
);
  import rc_fc_pkg::*;

  frame_end_t frame_end;
  chan_set_t  pending;
  chan_set_t  accepted;
  logic       free;
  logic       take;

  assign cfg_ready = 1'b1;
  assign in_ready = free;
  assign take = in_valid && free;

  rc_fc_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .frame_end (frame_end),
    .pending   (pending)
  );

  rc_fc_result u_result (
    .clk       (clk),
    .rst       (rst),
    .frame_end (frame_end),
    .pending   (pending),
    .out_ready (out_ready),
    .free      (free),
    .out_valid (out_valid),
    .status    (status),
    .accepted  (accepted)
  );

  assign throttle    = accepted[0];
  assign yaw_stick   = accepted[1];
  assign roll_stick  = accepted[2];
  assign pitch_stick = accepted[3];
  assign aux_one     = accepted[4];
  assign aux_two     = accepted[5];
  assign aux_three   = accepted[6];
  assign aux_four    = accepted[7];
  assign aux_five    = accepted[8];
  assign aux_six     = accepted[9];

endmodule

[src/rc_fc_assert.sv]
`include "rc_frame_checker_macros.svh"

module rc_fc_assert (
  input logic               clk,
  input logic               rst,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [7:0]         cfg_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         data_byte,
  input logic               last_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         status,
  input logic signed [15:0] throttle,
  input logic signed [15:0] yaw_stick,
  input logic signed [15:0] roll_stick,
  input logic signed [15:0] pitch_stick,
  input logic signed [15:0] aux_one,
  input logic signed [15:0] aux_two,
  input logic signed [15:0] aux_three,
  input logic signed [15:0] aux_four,
  input logic signed [15:0] aux_five,
  input logic signed [15:0] aux_six
);
  import rc_fc_pkg::*;

  // a stalled result holds
  `RC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result dropped while stalled")

  // empty output stage never blocks input
  `RC_ASSERT_NOW(a_in_free, !out_valid, in_ready, "input blocked with no result pending")

  // a mid-frame byte produces no result
  `RC_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && !last_byte && !out_valid, !out_valid, "result without a last byte")

  // throttle and aux_six move only with a good frame
  `RC_ASSERT_NOW(a_chan_ok, !$stable(throttle) || !$stable(aux_six), out_valid && status == ST_OK, "channels changed without a good frame")

endmodule

bind rc_frame_checker rc_fc_assert u_rc_fc_assert (.*);

[sim/rc_frame_report_checker.sv]
`timescale 1ns / 1ps
module rc_frame_report_checker #(
  parameter int unsigned MAX_BYTES = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         status,
  input  logic signed [15:0] throttle,
  input  logic signed [15:0] yaw_stick,
  input  logic signed [15:0] roll_stick,
  input  logic signed [15:0] pitch_stick,
  input  logic signed [15:0] aux_one,
  input  logic signed [15:0] aux_two,
  input  logic signed [15:0] aux_three,
  input  logic signed [15:0] aux_four,
  input  logic signed [15:0] aux_five,
  input  logic signed [15:0] aux_six,
  output int                 fails,
  output int                 waiting,
  output int                 reports_seen,
  output int                 frames_taken
);
  import rc_fc_pkg::*;

  localparam int unsigned TAIL_BYTES = 4;

  typedef struct {
    status_t   status;
    chan_set_t chans;
  } frame_report_t;

  frame_report_t expected_reports[$];

  logic [7:0]            func_code;
  logic [7:0]            byte_idx;
  logic                  hdr_ok;
  logic                  fn_ok;
  logic [31:0]           sum_acc;
  logic [TAIL_BYTES-1:0][7:0] tail_win;
  chan_set_t             pend_ch;
  chan_set_t             held_ch;
  chan_set_t             got_chans;

  string chan_names [CHANNELS] = '{"throttle", "yaw_stick", "roll_stick", "pitch_stick",
                                   "aux_one", "aux_two", "aux_three", "aux_four",
                                   "aux_five", "aux_six"};

  assign got_chans = {aux_six, aux_five, aux_four, aux_three, aux_two, aux_one,
                      pitch_stick, roll_stick, yaw_stick, throttle};

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic void restart_frame();
    byte_idx = '0;
    hdr_ok = 1'b1;
    fn_ok = 1'b1;
    sum_acc = '0;
    tail_win = '0;
  endfunction

  // tail_win[3] is the oldest byte, so the window read as a word is the
  // big-endian checksum at the end of a frame
  function automatic void predict_frame_byte(input logic [7:0] b, input logic fin);
    int unsigned idx;
    int unsigned len;
    int unsigned ch;
    frame_report_t rep;
    idx = byte_idx;
    if (idx == 0) begin
      hdr_ok = (b == HEADER_FIRST);
    end else if (idx == 1) begin
      hdr_ok = hdr_ok && (b == HEADER_SECOND);
    end else if (idx == 2) begin
      fn_ok = (b == func_code);
    end
    if (idx >= CHAN_FIRST_BYTE && idx < CHAN_FIRST_BYTE + CHAN_BYTES) begin
      ch = (idx - CHAN_FIRST_BYTE) / 2;
      if (((idx - CHAN_FIRST_BYTE) % 2) == 0) begin
        pend_ch[ch][15:8] = b;
      end else begin
        pend_ch[ch][7:0] = b;
      end
    end
    if (idx >= TAIL_BYTES) begin
      sum_acc += 32'(tail_win[3]);
    end
    tail_win = {tail_win[2:0], b};
    if (byte_idx != 8'hFF) begin
      byte_idx++;
    end
    if (!fin) begin
      return;
    end
    len = (idx == 255) ? 256 : idx + 1;
    if (len < MIN_FRAME_BYTES || len > MAX_BYTES) begin
      rep.status = ST_BAD_LEN;
    end else if (!hdr_ok) begin
      rep.status = ST_BAD_HEADER;
    end else if (!fn_ok) begin
      rep.status = ST_BAD_FUNC;
    end else if (32'(tail_win) != sum_acc) begin
      rep.status = ST_BAD_SUM;
    end else begin
      rep.status = ST_OK;
    end
    if (rep.status == ST_OK) begin
      held_ch = pend_ch;
      frames_taken++;
    end
    rep.chans = held_ch;
    expected_reports.push_back(rep);
    restart_frame();
  endfunction

  always @(posedge clk) begin
    frame_report_t want;
    if (rst) begin
      func_code = FUNCTION_RESET;
      restart_frame();
      pend_ch = '0;
      held_ch = '0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result with status %0d and no request pending", status));
        end else begin
          want = expected_reports.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("result %0d status: got %0d expected %0d",
                                      reports_seen, status, want.status));
          end
          for (int k = 0; k < CHANNELS; k++) begin
            if (got_chans[k] !== want.chans[k]) begin
              report_mismatch($sformatf("result %0d %s: got %0d expected %0d",
                                        reports_seen, chan_names[k],
                                        $signed(got_chans[k]), $signed(want.chans[k])));
            end
          end
        end
        reports_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        func_code = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict_frame_byte(data_byte, last_byte);
      end
    end
    waiting <= expected_reports.size();
  end

endmodule

[sim/rc_frame_checker_tb.sv]
`timescale 1ns / 1ps
module rc_frame_checker_tb;
  import rc_fc_pkg::*;

  localparam int unsigned MAX_BYTES = 255;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [4:0] F_NONE  = 5'b00000;
  localparam logic [4:0] F_HDR0  = 5'b00001;
  localparam logic [4:0] F_HDR1  = 5'b00010;
  localparam logic [4:0] F_FUNC  = 5'b00100;
  localparam logic [4:0] F_SUM   = 5'b01000;
  localparam logic [4:0] F_NOISE = 5'b10000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = '0;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic signed [15:0] throttle, yaw_stick, roll_stick, pitch_stick;
  logic signed [15:0] aux_one, aux_two, aux_three, aux_four, aux_five, aux_six;

  int fails, waiting, reports_seen, frames_taken;
  int cycle_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int hold_request = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  logic [7:0] cur_code = FUNCTION_RESET;
  logic [7:0] frame_buf[$];

  rc_frame_checker #(
    .MAX_FRAME_BYTES(MAX_BYTES)
  ) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .throttle(throttle), .yaw_stick(yaw_stick), .roll_stick(roll_stick),
    .pitch_stick(pitch_stick), .aux_one(aux_one), .aux_two(aux_two),
    .aux_three(aux_three), .aux_four(aux_four), .aux_five(aux_five), .aux_six(aux_six)
  );

  rc_frame_report_checker #(
    .MAX_BYTES(MAX_BYTES)
  ) report_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .throttle(throttle), .yaw_stick(yaw_stick), .roll_stick(roll_stick),
    .pitch_stick(pitch_stick), .aux_one(aux_one), .aux_two(aux_two),
    .aux_three(aux_three), .aux_four(aux_four), .aux_five(aux_five), .aux_six(aux_six),
    .fails(fails), .waiting(waiting), .reports_seen(reports_seen),
    .frames_taken(frames_taken)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic fill_frame(input int len);
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    if (len > 0) frame_buf[0] = HEADER_FIRST;
    if (len > 1) frame_buf[1] = HEADER_SECOND;
    if (len > 2) frame_buf[2] = cur_code;
  endtask

  task automatic set_all_channels(input logic [15:0] v);
    for (int k = 0; k < CHANNELS; k++) begin
      frame_buf[CHAN_FIRST_BYTE + 2 * k] = v[15:8];
      frame_buf[CHAN_FIRST_BYTE + 2 * k + 1] = v[7:0];
    end
  endtask

  task automatic finish_frame(input logic [4:0] faults);
    logic [31:0] sum;
    int n;
    n = frame_buf.size();
    if (faults & F_NOISE) begin
      foreach (frame_buf[i]) frame_buf[i] = 8'($urandom_range(0, 255));
      return;
    end
    if ((faults & F_HDR0) && n > 0) frame_buf[0] ^= 8'($urandom_range(1, 255));
    if ((faults & F_HDR1) && n > 1) frame_buf[1] ^= 8'($urandom_range(1, 255));
    if ((faults & F_FUNC) && n > 2) frame_buf[2] ^= 8'($urandom_range(1, 255));
    sum = '0;
    for (int i = 0; i < n - 4; i++) begin
      sum += 32'(frame_buf[i]);
    end
    if (n >= 4) begin
      for (int k = 0; k < 4; k++) begin
        frame_buf[n - 4 + k] = sum[31 - 8 * k -: 8];
      end
      if (faults & F_SUM) begin
        frame_buf[n - 1 - $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
    frames_sent++;
  endtask

  task automatic run_frame(input int len, input logic [4:0] faults);
    fill_frame(len);
    finish_frame(faults);
    send_frame();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_function_code(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_code = v;
  endtask

  task automatic random_phase(input int byte_goal, input int frame_goal);
    int start_bytes;
    int start_frames;
    int pick;
    int len;
    logic [4:0] faults;
    start_bytes = bytes_sent;
    start_frames = frames_sent;
    while (bytes_sent - start_bytes < byte_goal || frames_sent - start_frames < frame_goal) begin
      pick = $urandom_range(0, 99);
      faults = F_NONE;
      if (pick < 60) begin
        len = $urandom_range(28, 40);
      end else if (pick < 80) begin
        len = $urandom_range(28, 40);
        faults = 5'($urandom_range(1, 15));
      end else if (pick < 90) begin
        len = $urandom_range(1, 27);
        faults = 5'($urandom_range(0, 15));
      end else begin
        len = $urandom_range(1, 40);
        faults = F_NOISE;
      end
      run_frame(len, faults);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    run_frame(28, F_NONE);
    fill_frame(28);
    set_all_channels(16'h8000);
    finish_frame(F_NONE);
    send_frame();
    fill_frame(28);
    set_all_channels(16'h7FFF);
    finish_frame(F_NONE);
    send_frame();
    fill_frame(MAX_BYTES);
    for (int i = 3; i < MAX_BYTES; i++) frame_buf[i] = 8'hFF;
    finish_frame(F_NONE);
    send_frame();
    run_frame(27, F_NONE);
    run_frame(1, F_NONE);
    run_frame(256, F_NONE);
    run_frame(28, F_HDR0);
    run_frame(28, F_HDR1);
    run_frame(28, F_FUNC);
    run_frame(28, F_SUM);

    write_function_code(8'h00);
    random_phase(30, 1);

    write_function_code(8'hFF);
    // long hold-off on results while short frames keep coming
    hold_request = 80;
    repeat (12) run_frame($urandom_range(1, 3), F_NONE);
    random_phase(30, 1);

    write_function_code(8'($urandom_range(0, 255)));
    random_phase(30, 1);

    write_function_code(FUNCTION_RESET);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(30, 1);

    drain();
    repeat (5) @(posedge clk);
    $display("Run covered %0d frames in %0d bytes, %0d results checked, %0d frames accepted.",
             frames_sent, bytes_sent, reports_seen, frames_taken);
    $display("Function codes 0x03, 0x00, 0xFF and one random; length, header, function and");
    $display("checksum faults; result hold-off and idle bursts on both sides.");
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
